// ===== hw/rtl/elu_activation_core_macros.svh =====
// Assertion macros shared by the ELU activation core
`ifndef ELU_ACTIVATION_CORE_MACROS_SVH
`define ELU_ACTIVATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ELU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ELU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/elu_pkg.sv =====
// Shared types, constants and exp table functions for the ELU activation core
`timescale 1ns / 1ps

package elu_pkg;

  localparam int unsigned TAYLOR_TERMS = 24;
  localparam int unsigned EXP_FRAC     = 30;
  localparam int unsigned EXP_W        = EXP_FRAC + 1;
  localparam logic [63:0] ONE_Q30      = 64'd1 << EXP_FRAC;
  localparam logic [63:0] HALF_Q30     = 64'd1 << (EXP_FRAC - 1);

  localparam int unsigned ALPHA_W      = 16;
  localparam int unsigned ALPHA_FRAC   = 12;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4096;

  localparam int unsigned PROD_W       = ALPHA_W + EXP_W;
  localparam int unsigned PROD_FRAC    = ALPHA_FRAC + EXP_FRAC;

  typedef struct packed {
    logic valid;
    logic last;
    logic pass;
    logic far;
  } elu_ctl_t;

  // e^(-d) in Q30 from a truncated Taylor sum, step = d in Q30
  function automatic logic [63:0] exp_ratio(input logic [63:0] step);
    logic [63:0] term;
    logic [63:0] even;
    logic [63:0] odd;
    term = ONE_Q30;
    even = ONE_Q30;
    odd  = '0;
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = ((term * step) >> EXP_FRAC) / 64'(i);
      if (i[0]) begin
        odd = odd + term;
      end else begin
        even = even + term;
      end
    end
    return (even > odd) ? (even - odd) : 64'd0;
  endfunction

  // table point k: repeated multiply by the ratio, rounded half up
  function automatic logic [63:0] exp_point(input int k, input logic [63:0] ratio);
    logic [63:0] v;
    v = ONE_Q30;
    for (int j = 0; j < k; j++) begin
      v = (v * ratio + HALF_Q30) >> EXP_FRAC;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/elu_index.sv =====
// Input stage: sign test, magnitude, range check and table position
`timescale 1ns / 1ps

module elu_index import elu_pkg::*; #(
  parameter int DATA_WIDTH        = 16,
  parameter int FRAC_BITS         = 11,
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  logic                                   last_i,
  input  logic [DATA_WIDTH-1:0]                  sample_i,
  output logic                                   ready_o,
  output elu_ctl_t                               ctl_o,
  output logic [DATA_WIDTH-1:0]                  sample_o,
  output logic [$clog2(EXP_TABLE_ENTRIES+1)-1:0] idx_o,
  output logic [FRAC_BITS+2:0]                   frac_o,
  input  logic                                   ready_i
);

  localparam int IDX_W    = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_BITS = FRAC_BITS + 3;
  localparam int POS_A    = DATA_WIDTH + IDX_W;
  localparam int POS_W    = (POS_A > POS_BITS + IDX_W) ? POS_A : POS_BITS + IDX_W;
  localparam int CMP_W    = (DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4;
  localparam logic [CMP_W-1:0] FAR_LIM = CMP_W'(8) << FRAC_BITS;

  logic [DATA_WIDTH-1:0] mag;
  logic [POS_W-1:0]      pos;
  elu_ctl_t              ctl_nxt;
  elu_ctl_t              ctl_r;
  logic [DATA_WIDTH-1:0] sample_r;
  logic [IDX_W-1:0]      idx_r;
  logic [POS_BITS-1:0]   frac_r;

  always_comb begin
    mag           = '0 - sample_i;
    pos           = POS_W'(mag) * POS_W'(EXP_TABLE_ENTRIES);
    ctl_nxt.valid = valid_i;
    ctl_nxt.last  = last_i;
    ctl_nxt.pass  = (sample_i != '0) && !sample_i[DATA_WIDTH-1];
    ctl_nxt.far   = CMP_W'(mag) >= FAR_LIM;
  end

  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r <= ctl_nxt;
    end
  end

  // far and positive samples point at the first table entry
  always_ff @(posedge clk) begin
    if (ready_o) begin
      sample_r <= sample_i;
      idx_r    <= ctl_nxt.far ? '0 : pos[POS_BITS +: IDX_W];
      frac_r   <= ctl_nxt.far ? '0 : pos[POS_BITS-1:0];
    end
  end

  assign ctl_o    = ctl_r;
  assign sample_o = sample_r;
  assign idx_o    = idx_r;
  assign frac_o   = frac_r;

endmodule

// ===== hw/rtl/elu_interp.sv =====
// Exp table lookup, linear interpolation and 1 - exp, three stages
`timescale 1ns / 1ps
`include "elu_activation_core_macros.svh"

module elu_interp import elu_pkg::*; #(
  parameter int DATA_WIDTH        = 16,
  parameter int FRAC_BITS         = 11,
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  elu_ctl_t                               ctl_i,
  input  logic [DATA_WIDTH-1:0]                  sample_i,
  input  logic [$clog2(EXP_TABLE_ENTRIES+1)-1:0] idx_i,
  input  logic [FRAC_BITS+2:0]                   frac_i,
  output logic                                   ready_o,
  output elu_ctl_t                               ctl_o,
  output logic [DATA_WIDTH-1:0]                  sample_o,
  output logic [EXP_W-1:0]                       g_o,
  input  logic                                   ready_i
);

  localparam int IDX_W    = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_BITS = FRAC_BITS + 3;
  localparam int MUL_W    = EXP_W + POS_BITS;
  localparam logic [63:0] STEP  = (64'd8 << EXP_FRAC) / EXP_TABLE_ENTRIES;
  localparam logic [63:0] RATIO = exp_ratio(STEP);
  localparam logic [EXP_W-1:0] ONE = EXP_W'(ONE_Q30);

  logic [EXP_W-1:0] exp_tab [EXP_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_tab
    assign exp_tab[k] = EXP_W'(exp_point(k, RATIO));
  end

  // stage A: lookup
  elu_ctl_t              ctl_a_r;
  logic [DATA_WIDTH-1:0] sample_a_r;
  logic [EXP_W-1:0]      hi_a_r;
  logic [EXP_W-1:0]      diff_a_r;
  logic [POS_BITS-1:0]   frac_a_r;
  // stage B: interpolation product
  elu_ctl_t              ctl_b_r;
  logic [DATA_WIDTH-1:0] sample_b_r;
  logic [EXP_W-1:0]      hi_b_r;
  logic [MUL_W-1:0]      mul_b_r;
  // stage C: 1 - exp
  elu_ctl_t              ctl_c_r;
  logic [DATA_WIDTH-1:0] sample_c_r;
  logic [EXP_W-1:0]      g_r;

  logic                  rdy_a;
  logic                  rdy_b;
  logic                  rdy_c;
  logic [IDX_W-1:0]      idx_hi;
  logic [EXP_W-1:0]      hi_nxt;
  logic [EXP_W-1:0]      lo_nxt;
  logic [EXP_W-1:0]      e_val;
  logic [EXP_W-1:0]      g_nxt;

  assign rdy_c   = !ctl_c_r.valid || ready_i;
  assign rdy_b   = !ctl_b_r.valid || rdy_c;
  assign rdy_a   = !ctl_a_r.valid || rdy_b;
  assign ready_o = rdy_a;

  always_comb begin
    idx_hi = idx_i + IDX_W'(1);
    hi_nxt = exp_tab[idx_i];
    lo_nxt = exp_tab[idx_hi];
    e_val  = hi_b_r - EXP_W'(mul_b_r >> POS_BITS);
    g_nxt  = ctl_b_r.far ? ONE : (ONE - e_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      if (rdy_a) begin
        ctl_a_r <= ctl_i;
      end
      if (rdy_b) begin
        ctl_b_r <= ctl_a_r;
      end
      if (rdy_c) begin
        ctl_c_r <= ctl_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      sample_a_r <= sample_i;
      hi_a_r     <= hi_nxt;
      diff_a_r   <= hi_nxt - lo_nxt;
      frac_a_r   <= frac_i;
    end
    if (rdy_b) begin
      sample_b_r <= sample_a_r;
      hi_b_r     <= hi_a_r;
      mul_b_r    <= MUL_W'(diff_a_r) * MUL_W'(frac_a_r);
    end
    if (rdy_c) begin
      sample_c_r <= sample_b_r;
      g_r        <= g_nxt;
    end
  end

  assign ctl_o    = ctl_c_r;
  assign sample_o = sample_c_r;
  assign g_o      = g_r;

  `ELU_ASSERT_NOW(a_g_bounded, ctl_c_r.valid, g_r <= ONE, "1 - exp above one")
  `ELU_ASSERT_NEXT(a_b_hold, ctl_b_r.valid && !rdy_c, ctl_b_r.valid && $stable(mul_b_r), "stage B lost data in stall")

endmodule

// ===== hw/rtl/elu_scale.sv =====
// Alpha scaling, rounding, saturation and output register
`timescale 1ns / 1ps
`include "elu_activation_core_macros.svh"

module elu_scale import elu_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ALPHA_W-1:0]    alpha_i,
  input  elu_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] sample_i,
  input  logic [EXP_W-1:0]      g_i,
  output logic                  ready_o,
  output logic                  out_valid,
  output logic                  out_last,
  output logic [DATA_WIDTH-1:0] out_sample,
  input  logic                  out_ready
);

  localparam int SHIFT = PROD_FRAC - FRAC_BITS;
  localparam logic [PROD_W-1:0] RND   = PROD_W'(1) << (SHIFT - 1);
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  elu_ctl_t              ctl_d_r;
  logic [DATA_WIDTH-1:0] sample_d_r;
  logic [PROD_W-1:0]     prod_r;
  elu_ctl_t              ctl_e_r;
  logic [DATA_WIDTH-1:0] sample_e_r;

  logic                  rdy_d;
  logic                  rdy_e;
  logic [PROD_W-1:0]     neg_mag;
  logic [DATA_WIDTH-1:0] result_nxt;

  assign rdy_e   = !ctl_e_r.valid || out_ready;
  assign rdy_d   = !ctl_d_r.valid || rdy_e;
  assign ready_o = rdy_d;

  always_comb begin
    neg_mag = (prod_r + RND) >> SHIFT;
    if (ctl_d_r.pass) begin
      result_nxt = sample_d_r;
    end else if (neg_mag > LIMIT) begin
      result_nxt = NEG_MIN;
    end else begin
      result_nxt = '0 - neg_mag[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
      ctl_e_r <= '0;
    end else begin
      if (rdy_d) begin
        ctl_d_r <= ctl_i;
      end
      if (rdy_e) begin
        ctl_e_r <= ctl_d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      sample_d_r <= sample_i;
      prod_r     <= PROD_W'(alpha_i) * PROD_W'(g_i);
    end
    if (rdy_e) begin
      sample_e_r <= result_nxt;
    end
  end

  assign out_valid  = ctl_e_r.valid;
  assign out_last   = ctl_e_r.last;
  assign out_sample = sample_e_r;

  `ELU_ASSERT_NOW(a_neg_sign, ctl_e_r.valid && !ctl_e_r.pass, sample_e_r[DATA_WIDTH-1] || (sample_e_r == '0), "negative path gave a positive result")
  `ELU_ASSERT_NEXT(a_d_hold, ctl_d_r.valid && !rdy_e, ctl_d_r.valid && $stable(prod_r), "stage D lost data in stall")

endmodule

// ===== hw/rtl/elu_activation_core.sv =====
// Top level of the ELU activation core: streaming ports and alpha register
//
//  channel | direction | tdata / data            | tuser | tlast
//  in_     | slave     | sample_in               | -     | last_in
//  out_    | master    | sample_out              | -     | last_out
//  cfg_    | write     | alpha_gain (Q4.12)      | -     | -
//
//  One beat per cycle while out_tready is high. Stages: index, lookup,
//  interpolation multiply, 1 - exp, alpha multiply, output register.
//  Each stage holds its beat while the stage after it is full, so a stall
//  on out_tready backs up stage by stage; empty stages still fill.
//  Synchronous active-low reset clears stage valids, alpha returns to 1.0.
`timescale 1ns / 1ps

module elu_activation_core import elu_pkg::*; #(
  parameter int DATA_WIDTH        = 16,
  parameter int FRAC_BITS         = 11,
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]    in_tdata,   // sample_in
  input  logic                               in_tlast,   // last_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]    out_tdata,  // sample_out
  output logic                               out_tlast,  // last_out
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ALPHA_W-1:0]                 cfg_data    // alpha_gain
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int IDX_W   = $clog2(EXP_TABLE_ENTRIES + 1);

  logic [ALPHA_W-1:0]    alpha_r;

  logic                  idx_ready;
  elu_ctl_t              idx_ctl;
  logic [DATA_WIDTH-1:0] idx_sample;
  logic [IDX_W-1:0]      idx_val;
  logic [FRAC_BITS+2:0]  idx_frac;

  logic                  int_ready;
  elu_ctl_t              int_ctl;
  logic [DATA_WIDTH-1:0] int_sample;
  logic [EXP_W-1:0]      int_g;

  logic                  scl_ready;
  logic [DATA_WIDTH-1:0] scl_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha_r <= cfg_data;
    end
  end

  elu_index #(
    .DATA_WIDTH        (DATA_WIDTH),
    .FRAC_BITS         (FRAC_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_tvalid),
    .last_i   (in_tlast),
    .sample_i (in_tdata[DATA_WIDTH-1:0]),
    .ready_o  (in_tready),
    .ctl_o    (idx_ctl),
    .sample_o (idx_sample),
    .idx_o    (idx_val),
    .frac_o   (idx_frac),
    .ready_i  (idx_ready)
  );

  elu_interp #(
    .DATA_WIDTH        (DATA_WIDTH),
    .FRAC_BITS         (FRAC_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (idx_ctl),
    .sample_i (idx_sample),
    .idx_i    (idx_val),
    .frac_i   (idx_frac),
    .ready_o  (idx_ready),
    .ctl_o    (int_ctl),
    .sample_o (int_sample),
    .g_o      (int_g),
    .ready_i  (int_ready)
  );

  elu_scale #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha_i    (alpha_r),
    .ctl_i      (int_ctl),
    .sample_i   (int_sample),
    .g_i        (int_g),
    .ready_o    (scl_ready),
    .out_valid  (out_tvalid),
    .out_last   (out_tlast),
    .out_sample (scl_sample),
    .out_ready  (out_tready)
  );

  assign int_ready = scl_ready;
  assign out_tdata = TDATA_W'(scl_sample);

endmodule

// ===== verif/elu_activation_core_test.sv =====
// Self-checking streaming testbench for the ELU activation core
`timescale 1ns / 1ps

module elu_activation_core_test;
  import elu_pkg::*;

  localparam int          SAMPLE_W    = 16;
  localparam int          LUT_POINTS  = 64;
  localparam int          LUT_POS_W   = 11 + 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_BEATS = 220;

  typedef struct packed {
    logic [SAMPLE_W-1:0] elem;
    logic                last_flag;
  } elu_beat_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;   // sample_in
  logic                in_tlast   = 1'b0; // last_in
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;         // sample_out
  logic                out_tlast;         // last_out
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [ALPHA_W-1:0]  cfg_data   = '0;   // alpha_gain

  longint unsigned exp_points [0:LUT_POINTS];
  logic [ALPHA_W-1:0] alpha_model = ALPHA_RESET;
  elu_beat_t          pending_beats[$];
  elu_beat_t          expected_results[$];
  elu_beat_t          next_beat;
  elu_beat_t          accepted_beat;
  elu_beat_t          due_beat;
  int                 burst_left    = 1;
  int                 gap_left      = 0;
  logic               steady_sender = 1'b0;
  int unsigned        cycle_count   = 0;
  int                 mismatch_count = 0;

  elu_activation_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exp(-k*8/64) in Q30, built from a truncated series and repeated products
  function automatic void fill_exp_points();
    longint unsigned step_q30;
    longint unsigned term;
    longint unsigned even_sum;
    longint unsigned odd_sum;
    longint unsigned ratio;
    step_q30 = (64'd8 << 30) / 64'(LUT_POINTS);
    term     = 64'd1 << 30;
    even_sum = 64'd1 << 30;
    odd_sum  = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step_q30) >> 30) / 64'(k);
      if (k % 2 == 1) begin
        odd_sum += term;
      end else begin
        even_sum += term;
      end
    end
    ratio = (even_sum > odd_sum) ? even_sum - odd_sum : 64'd0;
    exp_points[0] = 64'd1 << 30;
    for (int k = 1; k <= LUT_POINTS; k++) begin
      exp_points[k] = (exp_points[k-1] * ratio + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] elu_predict(input logic [SAMPLE_W-1:0] x,
                                                     input logic [ALPHA_W-1:0] alpha);
    longint unsigned magnitude;
    longint unsigned position;
    longint unsigned lut_idx;
    longint unsigned lut_frac;
    longint unsigned upper;
    longint unsigned lower;
    longint unsigned exp_q30;
    longint unsigned product;
    longint unsigned neg_mag;
    if (x != '0 && !x[SAMPLE_W-1]) begin
      return x;
    end
    magnitude = 64'(16'(~x + 16'd1));
    if (magnitude >= (64'd8 << 11)) begin
      exp_q30 = 64'd0;
    end else begin
      position = magnitude * 64'(LUT_POINTS);
      lut_idx  = position >> LUT_POS_W;
      lut_frac = position & ((64'd1 << LUT_POS_W) - 64'd1);
      upper    = exp_points[lut_idx];
      lower    = exp_points[lut_idx + 1];
      exp_q30  = upper - (((upper - lower) * lut_frac) >> LUT_POS_W);
    end
    product = 64'(alpha) * ((64'd1 << 30) - exp_q30);
    neg_mag = (product + (64'd1 << 30)) >> 31;
    if (neg_mag > (64'd1 << (SAMPLE_W - 1))) begin
      neg_mag = 64'd1 << (SAMPLE_W - 1);
    end
    return SAMPLE_W'(64'd0 - neg_mag);
  endfunction

  function automatic elu_beat_t random_beat();
    elu_beat_t b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b.elem = SAMPLE_W'(-int'($urandom_range(0, 16384)));
      4: begin
        case ($urandom_range(0, 5))
          0: b.elem = 16'h0000;
          1: b.elem = 16'h8000;
          2: b.elem = 16'h7FFF;
          3: b.elem = 16'hC000;
          4: b.elem = SAMPLE_W'(-int'(256 * $urandom_range(0, 64)));
          default: b.elem = 16'hFFFF;
        endcase
      end
      5: b.elem = SAMPLE_W'($urandom_range(1, 4096));
      default: b.elem = SAMPLE_W'($urandom);
    endcase
    b.last_flag = ($urandom_range(0, 15) == 0);
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_alpha(input logic [ALPHA_W-1:0] gain);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    alpha_model = gain;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_beat.elem      = elu_predict(in_tdata, alpha_model);
        accepted_beat.last_flag = in_tlast;
        expected_results.push_back(accepted_beat);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.elem;
          in_tlast  <= next_beat.last_flag;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = (steady_sender || $urandom_range(0, 2) == 0) ? 0 :
                         $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // receiver: stall pattern chosen by cycle_count bits 10:9, four patterns in turn
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected beat: sample_out %0d, last_out %0b",
                 $signed(out_tdata), out_tlast);
          mismatch_count++;
        end else begin
          due_beat = expected_results.pop_front();
          if (out_tdata !== due_beat.elem) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(due_beat.elem), $signed(out_tdata));
            mismatch_count++;
          end
          if (out_tlast !== due_beat.last_flag) begin
            $error("last_out: expected %0b, got %0b", due_beat.last_flag, out_tlast);
            mismatch_count++;
          end
        end
      end
      case (cycle_count[10:9])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= (cycle_count[3:0] < 4'd5);
        default: out_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] directed [] = '{
      16'h0000, 16'h0001, 16'h7FFF, 16'h0800, 16'hFFFF, 16'hFFFE,
      16'hFF01, 16'hFF00, 16'hFEFF, 16'hF800, 16'hE000, 16'hC001,
      16'hC000, 16'hBFFF, 16'h8001, 16'h8000, 16'h5555, 16'hAAAA};
    logic [ALPHA_W-1:0] phase_alpha [] = '{
      16'hFFFF, 16'h0000, 16'h0001, ALPHA_RESET, 16'h8000,
      16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
    elu_beat_t b;

    fill_exp_points();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of alpha, edge samples
    foreach (directed[i]) begin
      b.elem      = directed[i];
      b.last_flag = (i % 5 == 4) || (i == directed.size() - 1);
      pending_beats.push_back(b);
    end

    foreach (phase_alpha[p]) begin
      wait_drained();
      write_alpha((p >= 5 && p <= 7) ? ALPHA_W'($urandom) : phase_alpha[p]);
      steady_sender = (p % 3 == 2);
      repeat (PHASE_BEATS) pending_beats.push_back(random_beat());
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
